>>> hdl/wav_pcm_stream_parser_macros.svh
// assertion macros for the checker of the parser
`ifndef WAV_PCM_STREAM_PARSER_MACROS_SVH
`define WAV_PCM_STREAM_PARSER_MACROS_SVH

// checked only while out of reset
`define WPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("wps assertion failed");

// checked in reset as well
`define WPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("wps assertion failed");

`endif

>>> hdl/wps_pkg.sv
package wps_pkg;

  localparam int WPS_QUEUE_DEPTH = 3;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HEADER  = 3'd1,
    ST_MISSING = 3'd2,
    ST_NOT_PCM = 3'd3,
    ST_NOT_MONO = 3'd4,
    ST_BITS    = 3'd5
  } wps_status_t;

  typedef enum logic [3:0] {
    PH_HEADER      = 4'd0,
    PH_CHUNK_HDR   = 4'd1,
    PH_FMT         = 4'd2,
    PH_SKIP        = 4'd3,
    PH_PAD         = 4'd4,
    PH_DATA        = 4'd5,
    PH_DONE        = 4'd6,
    PH_ERR_HEADER  = 4'd8,
    PH_ERR_MISSING = 4'd9,
    PH_ERR_PCM     = 4'd10,
    PH_ERR_MONO    = 4'd11,
    PH_ERR_BITS    = 4'd12
  } wps_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } wps_in_t;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] sample;
    logic [2:0]         status;
    logic [31:0]        sample_rate;
  } wps_out_t;

  // results produced by one accepted byte, in order
  typedef struct packed {
    logic [1:0] count;
    wps_out_t   res0;
    wps_out_t   res1;
  } wps_push_t;

endpackage

>>> hdl/wps_stream_if.sv
interface wps_stream_if #(
  parameter type item_t = logic [7:0]
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/wav_pcm_stream_parser.sv
// WAV byte-stream parser, mono PCM 16 or 24 bit
// in_chan carries one byte of the file per item with an end_of_file flag on
// the final byte. out_chan carries results: audio samples as signed Q1.23
// (16-bit samples shifted left by 8) and, after the final byte, one status
// item holding the code and the sample rate from the fmt chunk.
// Each byte updates the parser state in the cycle it is accepted; its
// results sit in a small output queue and, if it was empty, show on
// out_chan from the next cycle. One byte is taken every cycle while the
// receiver keeps up; the final byte of a sample-completing file yields a
// sample and a status item, and the status shows in the cycle after the
// sample; at default depth in_chan.ready drops for one cycle, as it shows.
// in_chan.ready drops while the queue holds more than QUEUE_DEPTH-2 items,
// so a stalled receiver stops the byte stream once QUEUE_DEPTH-1 results
// wait (QUEUE_DEPTH after a final byte); nothing is dropped and queued items
// hold steady.
// Reset (rst_n low, synchronous) empties the queue and returns the parser
// to the header phase; the parser also returns there after each final byte.
module wav_pcm_stream_parser #(
  parameter int QUEUE_DEPTH = wps_pkg::WPS_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  wps_stream_if.sink   in_chan,
  wps_stream_if.source out_chan
);
  import wps_pkg::*;

  wps_push_t push;
  logic      room;
  logic      accept;

  assign in_chan.ready = room;
  assign accept = in_chan.valid && room;

  wps_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_chan.data),
    .push    (push)
  );

  wps_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

>>> hdl/wps_parser.sv
module wps_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  wps_pkg::wps_in_t  in_item,
  output wps_pkg::wps_push_t push
);
  import wps_pkg::*;

  wps_phase_t  phase_r, phase_nxt;
  logic [31:0] byte_count_r, byte_count_nxt;
  logic [31:0] chunk_id_r, chunk_id_nxt;
  logic [31:0] chunk_length_r, chunk_length_nxt;
  logic [15:0] format_tag_r, format_tag_nxt;
  logic [15:0] channel_count_r, channel_count_nxt;
  logic [31:0] rate_value_r, rate_value_nxt;
  logic [15:0] sample_bits_r, sample_bits_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic        pad_pending_r, pad_pending_nxt;
  logic [23:0] sample_accum_r, sample_accum_nxt;
  logic [1:0]  sample_index_r, sample_index_nxt;

  logic [7:0]  b;
  logic [31:0] id_w;
  logic [31:0] len_w;
  logic [31:0] count_inc;
  logic [23:0] acc_w;
  logic [2:0]  index_inc;
  logic        need3;
  logic        emit;
  wps_out_t    sample_res;
  wps_out_t    status_res;
  wps_status_t st;

  always_comb begin
    phase_nxt         = phase_r;
    byte_count_nxt    = byte_count_r;
    chunk_id_nxt      = chunk_id_r;
    chunk_length_nxt  = chunk_length_r;
    format_tag_nxt    = format_tag_r;
    channel_count_nxt = channel_count_r;
    rate_value_nxt    = rate_value_r;
    sample_bits_nxt   = sample_bits_r;
    fmt_seen_nxt      = fmt_seen_r;
    pad_pending_nxt   = pad_pending_r;
    sample_accum_nxt  = sample_accum_r;
    sample_index_nxt  = sample_index_r;

    b         = in_item.data_byte;
    id_w      = chunk_id_r;
    len_w     = chunk_length_r;
    count_inc = byte_count_r + 32'd1;
    acc_w     = sample_accum_r;
    index_inc = {1'b0, sample_index_r} + 3'd1;
    need3     = (sample_bits_r != 16'd16);
    emit      = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        id_w = {b, chunk_id_r[31:8]};
        chunk_id_nxt = id_w;
        if (byte_count_r == 32'd3 && id_w != ID_RIFF) begin
          phase_nxt = PH_ERR_HEADER;
        end else if (byte_count_r == 32'd11) begin
          if (id_w != ID_WAVE) begin
            phase_nxt = PH_ERR_HEADER;
          end else begin
            phase_nxt      = PH_CHUNK_HDR;
            byte_count_nxt = '0;
            chunk_id_nxt   = '0;
          end
        end else begin
          byte_count_nxt = count_inc;
        end
      end
      PH_CHUNK_HDR: begin
        if (byte_count_r < 32'd4) begin
          id_w = {b, chunk_id_r[31:8]};
        end else begin
          len_w = {b, chunk_length_r[31:8]};
        end
        chunk_id_nxt     = id_w;
        chunk_length_nxt = len_w;
        byte_count_nxt   = count_inc;
        if (count_inc == 32'd8) begin
          // chunk header complete
          pad_pending_nxt = len_w[0];
          byte_count_nxt  = '0;
          if (id_w == ID_FMT) begin
            format_tag_nxt    = '0;
            channel_count_nxt = '0;
            rate_value_nxt    = '0;
            sample_bits_nxt   = '0;
            fmt_seen_nxt      = 1'b1;
            phase_nxt = (len_w == '0) ? PH_CHUNK_HDR : PH_FMT;
          end else if (id_w == ID_DATA) begin
            if (!fmt_seen_r) begin
              phase_nxt = PH_ERR_MISSING;
            end else if (format_tag_r != 16'd1) begin
              phase_nxt = PH_ERR_PCM;
            end else if (channel_count_r != 16'd1) begin
              phase_nxt = PH_ERR_MONO;
            end else if (sample_bits_r != 16'd16 && sample_bits_r != 16'd24) begin
              phase_nxt = PH_ERR_BITS;
            end else begin
              sample_accum_nxt = '0;
              sample_index_nxt = '0;
              phase_nxt = (len_w == '0) ? PH_DONE : PH_DATA;
            end
          end else begin
            phase_nxt = (len_w == '0) ? PH_CHUNK_HDR : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        if (byte_count_r == 32'd0) format_tag_nxt[7:0]     = format_tag_r[7:0] | b;
        if (byte_count_r == 32'd1) format_tag_nxt[15:8]    = format_tag_r[15:8] | b;
        if (byte_count_r == 32'd2) channel_count_nxt[7:0]  = channel_count_r[7:0] | b;
        if (byte_count_r == 32'd3) channel_count_nxt[15:8] = channel_count_r[15:8] | b;
        if (byte_count_r == 32'd4) rate_value_nxt[7:0]     = rate_value_r[7:0] | b;
        if (byte_count_r == 32'd5) rate_value_nxt[15:8]    = rate_value_r[15:8] | b;
        if (byte_count_r == 32'd6) rate_value_nxt[23:16]   = rate_value_r[23:16] | b;
        if (byte_count_r == 32'd7) rate_value_nxt[31:24]   = rate_value_r[31:24] | b;
        if (byte_count_r == 32'd14) sample_bits_nxt[7:0]   = sample_bits_r[7:0] | b;
        if (byte_count_r == 32'd15) sample_bits_nxt[15:8]  = sample_bits_r[15:8] | b;
        byte_count_nxt = count_inc;
        if (count_inc == chunk_length_r) begin
          byte_count_nxt = '0;
          phase_nxt = pad_pending_r ? PH_PAD : PH_CHUNK_HDR;
        end
      end
      PH_SKIP: begin
        byte_count_nxt = count_inc;
        if (count_inc == chunk_length_r) begin
          byte_count_nxt = '0;
          phase_nxt = pad_pending_r ? PH_PAD : PH_CHUNK_HDR;
        end
      end
      PH_PAD: begin
        pad_pending_nxt = 1'b0;
        byte_count_nxt  = '0;
        phase_nxt       = PH_CHUNK_HDR;
      end
      PH_DATA: begin
        unique case (sample_index_r)
          2'd0:    acc_w[7:0]   = sample_accum_r[7:0] | b;
          2'd1:    acc_w[15:8]  = sample_accum_r[15:8] | b;
          2'd2:    acc_w[23:16] = sample_accum_r[23:16] | b;
          default: acc_w        = sample_accum_r;
        endcase
        emit = (index_inc >= (need3 ? 3'd3 : 3'd2));
        if (emit) begin
          sample_accum_nxt = '0;
          sample_index_nxt = '0;
        end else begin
          sample_accum_nxt = acc_w;
          sample_index_nxt = index_inc[1:0];
        end
        byte_count_nxt = count_inc;
        if (count_inc == chunk_length_r) begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    sample_res.kind        = KIND_SAMPLE;
    sample_res.sample      = need3 ? acc_w : {acc_w[15:0], 8'h00};
    sample_res.status      = ST_OK;
    sample_res.sample_rate = '0;

    unique case (phase_nxt)
      PH_HEADER:      st = ST_HEADER;
      PH_ERR_HEADER:  st = ST_HEADER;
      PH_ERR_MISSING: st = ST_MISSING;
      PH_ERR_PCM:     st = ST_NOT_PCM;
      PH_ERR_MONO:    st = ST_NOT_MONO;
      PH_ERR_BITS:    st = ST_BITS;
      PH_DATA:        st = ST_OK;
      PH_DONE:        st = ST_OK;
      default:        st = ST_MISSING;
    endcase

    status_res.kind        = KIND_STATUS;
    status_res.sample      = '0;
    status_res.status      = st;
    status_res.sample_rate = rate_value_nxt;

    push.count = {1'b0, emit} + {1'b0, in_item.end_of_file};
    push.res0  = emit ? sample_res : status_res;
    push.res1  = status_res;

    // last byte of the file: back to the reset state
    if (in_item.end_of_file) begin
      phase_nxt         = PH_HEADER;
      byte_count_nxt    = '0;
      chunk_id_nxt      = '0;
      chunk_length_nxt  = '0;
      format_tag_nxt    = '0;
      channel_count_nxt = '0;
      rate_value_nxt    = '0;
      sample_bits_nxt   = '0;
      fmt_seen_nxt      = 1'b0;
      pad_pending_nxt   = 1'b0;
      sample_accum_nxt  = '0;
      sample_index_nxt  = '0;
    end

    if (!accept) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      byte_count_r    <= '0;
      chunk_id_r      <= '0;
      chunk_length_r  <= '0;
      format_tag_r    <= '0;
      channel_count_r <= '0;
      rate_value_r    <= '0;
      sample_bits_r   <= '0;
      fmt_seen_r      <= 1'b0;
      pad_pending_r   <= 1'b0;
      sample_accum_r  <= '0;
      sample_index_r  <= '0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      byte_count_r    <= byte_count_nxt;
      chunk_id_r      <= chunk_id_nxt;
      chunk_length_r  <= chunk_length_nxt;
      format_tag_r    <= format_tag_nxt;
      channel_count_r <= channel_count_nxt;
      rate_value_r    <= rate_value_nxt;
      sample_bits_r   <= sample_bits_nxt;
      fmt_seen_r      <= fmt_seen_nxt;
      pad_pending_r   <= pad_pending_nxt;
      sample_accum_r  <= sample_accum_nxt;
      sample_index_r  <= sample_index_nxt;
    end
  end

endmodule

>>> hdl/wps_out_queue.sv
module wps_out_queue #(
  parameter int DEPTH = wps_pkg::WPS_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wps_pkg::wps_push_t push,
  output logic               room,
  wps_stream_if.source       out_chan
);
  import wps_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH + 1);
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

  wps_out_t      entry_r [DEPTH];
  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] sum0, sum1;
  logic [PW-1:0] tail0, tail1;
  logic          pop;

  assign out_chan.valid = (count_r != '0);
  assign out_chan.data  = entry_r[head_r];
  assign pop  = out_chan.valid && out_chan.ready;
  // room for the two results a last byte can produce
  assign room = (count_r <= ROOM_MAX);

  always_comb begin
    sum0  = SW'(head_r) + SW'(count_r);
    sum1  = sum0 + SW'(1);
    tail0 = (sum0 >= DEPTH_S) ? PW'(sum0 - DEPTH_S) : PW'(sum0);
    tail1 = (sum1 >= DEPTH_S) ? PW'(sum1 - DEPTH_S) : PW'(sum1);
    head_nxt = head_r;
    if (pop) begin
      head_nxt = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + PW'(1);
    end
    count_nxt = count_r + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry_r[tail0] <= push.res0;
    end
    if (push.count == 2'd2) begin
      entry_r[tail1] <= push.res1;
    end
  end

endmodule

>>> hdl/wps_checker.sv
`include "wav_pcm_stream_parser_macros.svh"

module wps_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input wps_pkg::wps_out_t out_data
);
  import wps_pkg::*;

  // queue is empty straight after reset
  `WPS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)
  // input only stalls while results wait
  `WPS_ASSERT(a_stall_has_items, clk, rst_n, !in_ready |-> out_valid)
  `WPS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `WPS_ASSERT(a_status_range, clk, rst_n, out_valid && out_data.kind == KIND_STATUS |-> out_data.status <= ST_BITS && out_data.sample == '0)

endmodule

bind wav_pcm_stream_parser wps_checker u_wps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

>>> tb/wav_pcm_stream_parser_test.sv
`timescale 1ns / 100ps

module wav_pcm_stream_parser_test;
  import wps_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RANDOM_BYTES = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [31:0] ID_LIST = 32'h5453_494C;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wps_stream_if #(.item_t(wps_in_t)) byte_chan ();
  wps_stream_if #(.item_t(wps_out_t)) result_chan ();

  wav_pcm_stream_parser DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (byte_chan),
    .out_chan (result_chan)
  );

  always #CLK_HALF clk = ~clk;

  // stimulus and scoreboard storage
  logic [7:0] file_bytes[$];
  wps_in_t    pending_bytes[$];
  wps_out_t   expected_results[$];

  int files_built = 0;
  int bytes_accepted = 0;
  int samples_checked = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int status_seen[8];

  // parser prediction state
  wps_phase_t  wav_phase;
  logic [31:0] hdr_count;
  logic [31:0] cur_id;
  logic [31:0] cur_len;
  logic [15:0] fmt_tag;
  logic [15:0] fmt_chans;
  logic [31:0] fmt_rate;
  logic [15:0] fmt_bits;
  logic        have_fmt;
  logic        pad_due;
  logic [23:0] accum;
  logic [1:0]  accum_idx;

  task automatic reset_model();
    wav_phase = PH_HEADER;
    hdr_count = '0;
    cur_id = '0;
    cur_len = '0;
    fmt_tag = '0;
    fmt_chans = '0;
    fmt_rate = '0;
    fmt_bits = '0;
    have_fmt = 1'b0;
    pad_due = 1'b0;
    accum = '0;
    accum_idx = '0;
  endtask

  task automatic close_chunk();
    hdr_count = '0;
    wav_phase = pad_due ? PH_PAD : PH_CHUNK_HDR;
  endtask

  task automatic open_chunk();
    pad_due = cur_len[0];
    hdr_count = '0;
    if (cur_id == ID_FMT) begin
      // a new fmt chunk wipes whatever an earlier one set
      fmt_tag = '0;
      fmt_chans = '0;
      fmt_rate = '0;
      fmt_bits = '0;
      have_fmt = 1'b1;
      if (cur_len == 0) close_chunk();
      else wav_phase = PH_FMT;
    end else if (cur_id == ID_DATA) begin
      if (!have_fmt) wav_phase = PH_ERR_MISSING;
      else if (fmt_tag != 16'd1) wav_phase = PH_ERR_PCM;
      else if (fmt_chans != 16'd1) wav_phase = PH_ERR_MONO;
      else if (fmt_bits != 16'd16 && fmt_bits != 16'd24) wav_phase = PH_ERR_BITS;
      else begin
        accum = '0;
        accum_idx = '0;
        wav_phase = (cur_len == 0) ? PH_DONE : PH_DATA;
      end
    end else if (cur_len == 0) begin
      close_chunk();
    end else begin
      wav_phase = PH_SKIP;
    end
  endtask

  task automatic predict_byte(input wps_in_t it);
    wps_out_t    res;
    wps_status_t code;
    logic [7:0]  b;
    logic [31:0] off;
    int          need;
    b = it.data_byte;
    case (wav_phase)
      PH_HEADER: begin
        cur_id = {b, cur_id[31:8]};
        if (hdr_count == 3 && cur_id != ID_RIFF) begin
          wav_phase = PH_ERR_HEADER;
        end else if (hdr_count == 11) begin
          if (cur_id != ID_WAVE) begin
            wav_phase = PH_ERR_HEADER;
          end else begin
            wav_phase = PH_CHUNK_HDR;
            hdr_count = '0;
            cur_id = '0;
          end
        end else begin
          hdr_count++;
        end
      end
      PH_CHUNK_HDR: begin
        if (hdr_count < 4) cur_id = {b, cur_id[31:8]};
        else cur_len = {b, cur_len[31:8]};
        hdr_count++;
        if (hdr_count == 8) open_chunk();
      end
      PH_FMT: begin
        off = hdr_count;
        if (off < 2) fmt_tag[8*off +: 8] = b;
        else if (off < 4) fmt_chans[8*(off-2) +: 8] = b;
        else if (off < 8) fmt_rate[8*(off-4) +: 8] = b;
        else if (off == 14 || off == 15) fmt_bits[8*(off-14) +: 8] = b;
        hdr_count++;
        if (hdr_count == cur_len) close_chunk();
      end
      PH_SKIP: begin
        hdr_count++;
        if (hdr_count == cur_len) close_chunk();
      end
      PH_PAD: begin
        pad_due = 1'b0;
        hdr_count = '0;
        wav_phase = PH_CHUNK_HDR;
      end
      PH_DATA: begin
        need = (fmt_bits == 16'd16) ? 2 : 3;
        accum[8*accum_idx +: 8] = b;
        accum_idx++;
        if (accum_idx >= need) begin
          res = '0;
          res.kind = KIND_SAMPLE;
          res.sample = (need == 2) ? {accum[15:0], 8'h00} : accum;
          expected_results.push_back(res);
          accum = '0;
          accum_idx = '0;
        end
        hdr_count++;
        if (hdr_count == cur_len) wav_phase = PH_DONE;
      end
      default: ;
    endcase

    if (it.end_of_file) begin
      case (wav_phase)
        PH_HEADER, PH_ERR_HEADER: code = ST_HEADER;
        PH_ERR_PCM:               code = ST_NOT_PCM;
        PH_ERR_MONO:              code = ST_NOT_MONO;
        PH_ERR_BITS:              code = ST_BITS;
        PH_DATA, PH_DONE:         code = ST_OK;
        default:                  code = ST_MISSING;
      endcase
      res = '0;
      res.kind = KIND_STATUS;
      res.status = code;
      res.sample_rate = fmt_rate;
      expected_results.push_back(res);
      reset_model();
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  // file building
  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_random(input int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  task automatic put_riff_head();
    put_le(ID_RIFF, 4);
    put_le($urandom, 4);
    put_le(ID_WAVE, 4);
  endtask

  // chunk with random body and the pad byte an odd size calls for
  task automatic put_filler(input logic [31:0] id, input logic [31:0] len);
    put_le(id, 4);
    put_le(len, 4);
    put_random(len);
    if (len[0]) put_random(1);
  endtask

  task automatic put_fmt(input logic [31:0] len, input logic [15:0] tag,
                         input logic [15:0] chans, input logic [31:0] rate,
                         input logic [15:0] wbits);
    logic [127:0] body;
    body = {wbits, 16'($urandom), 32'($urandom), rate, chans, tag};
    put_le(ID_FMT, 4);
    put_le(len, 4);
    for (int i = 0; i < len; i++) begin
      if (i < 16) file_bytes.push_back(body[8*i +: 8]);
      else put_random(1);
    end
    if (len[0]) put_random(1);
  endtask

  task automatic put_wav(input logic [31:0] fmt_len, input logic [15:0] tag,
                         input logic [15:0] chans, input logic [31:0] rate,
                         input logic [15:0] wbits, input logic [31:0] data_len);
    put_riff_head();
    put_fmt(fmt_len, tag, chans, rate, wbits);
    put_filler(ID_DATA, data_len);
  endtask

  // keep = 0 sends the whole file, otherwise only its first keep bytes
  task automatic ship_file(input int keep);
    wps_in_t it;
    if (keep == 0) keep = file_bytes.size();
    for (int i = 0; i < keep; i++) begin
      it.data_byte = file_bytes[i];
      it.end_of_file = (i == keep - 1);
      pending_bytes.push_back(it);
    end
    file_bytes.delete();
    files_built++;
  endtask

  task automatic build_random_file();
    int          pick;
    int          keep;
    int          data_len;
    logic [31:0] fmt_len;
    logic [15:0] tag;
    logic [15:0] chans;
    logic [15:0] wbits;
    pick = $urandom_range(0, 99);
    tag = 16'd1;
    chans = 16'd1;
    wbits = $urandom_range(0, 1) ? 16'd16 : 16'd24;
    case ($urandom_range(0, 9))
      8:       fmt_len = $urandom_range(0, 15);
      9:       fmt_len = $urandom_range(17, 24);
      default: fmt_len = 16;
    endcase
    if (pick >= 95) begin
      // line noise
      put_random($urandom_range(1, 20));
    end else begin
      if (pick >= 70 && pick < 85) begin
        case ($urandom_range(0, 3))
          0: tag = 16'($urandom_range(0, 3));
          1: chans = 16'($urandom_range(0, 3));
          2: begin
            case ($urandom_range(0, 3))
              0:       wbits = 16'd8;
              1:       wbits = 16'd32;
              2:       wbits = 16'($urandom_range(0, 40));
              default: wbits = 16'($urandom);
            endcase
          end
          default: begin
            tag = 16'($urandom);
            chans = 16'($urandom);
            wbits = 16'($urandom);
          end
        endcase
      end
      put_riff_head();
      repeat ($urandom_range(0, 2))
        put_filler($urandom_range(0, 1) ? ID_LIST : $urandom, $urandom_range(0, 9));
      if (pick < 70 || $urandom_range(0, 4) != 0)
        put_fmt(fmt_len, tag, chans, $urandom, wbits);
      if ($urandom_range(0, 3) == 0) put_filler(ID_LIST, $urandom_range(0, 9));
      data_len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 150)
                                              : $urandom_range(0, 24);
      put_filler(ID_DATA, data_len);
      if ($urandom_range(0, 2) == 0) put_filler($urandom, $urandom_range(0, 6));
      if (pick >= 85) file_bytes[$urandom_range(0, 11)] ^= 8'($urandom_range(1, 255));
    end
    keep = ($urandom_range(0, 4) == 0) ? $urandom_range(1, file_bytes.size()) : 0;
    ship_file(keep);
  endtask

  // byte sender: bursts of random length with random gaps
  int gap_left;
  int burst_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      byte_chan.valid <= 1'b0;
      byte_chan.data <= '0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (!byte_chan.valid || byte_chan.ready) begin
      if (gap_left != 0) begin
        byte_chan.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_bytes.size() != 0) begin
        byte_chan.valid <= 1'b1;
        byte_chan.data <= pending_bytes.pop_front();
        if (burst_left != 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 30);
          gap_left <= $urandom_range(1, 12);
        end
      end else begin
        byte_chan.valid <= 1'b0;
      end
    end
  end

  // result receiver: stall modes of its own, plus two long hold-offs
  rx_mode_t   ready_mode;
  int         mode_left;
  logic [7:0] stall_pattern;
  int         hold_left;
  int         holds_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      result_chan.ready <= 1'b0;
      ready_mode <= RX_FLOW;
      mode_left <= 0;
      stall_pattern <= '0;
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      result_chan.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && bytes_accepted >= (holds_done == 0 ? 250 : 900)) begin
      // sender keeps going, so the output queue fills and backs up the input
      result_chan.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 300);
        stall_pattern <= 8'($urandom);
      end else begin
        mode_left <= mode_left - 1;
        stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      end
      case (ready_mode)
        RX_FLOW:    result_chan.ready <= 1'b1;
        RX_COIN:    result_chan.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:  result_chan.ready <= ($urandom_range(0, 9) == 0);
        default:    result_chan.ready <= stall_pattern[0];
      endcase
    end
  end

  // monitor: predict on each accepted byte, then check each accepted result
  always @(posedge clk) begin
    wps_out_t got;
    wps_out_t want;
    if (rst_n) begin
      if (byte_chan.valid && byte_chan.ready) begin
        predict_byte(byte_chan.data);
        bytes_accepted++;
      end
      if (result_chan.valid && result_chan.ready) begin
        got = result_chan.data;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got kind %0d sample %h status %0d rate %h",
                   $time, got.kind, got.sample, got.status, got.sample_rate);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("sample", {8'h00, want.sample}, {8'h00, got.sample});
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("sample_rate", want.sample_rate, got.sample_rate);
          if (want.kind == KIND_SAMPLE) samples_checked++;
          else status_seen[want.status]++;
        end
      end
      if ((byte_chan.valid && byte_chan.ready) || (result_chan.valid && result_chan.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, expected_results.size());
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int directed_bytes;
    byte_chan.valid = 1'b0;
    byte_chan.data = '0;
    result_chan.ready = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    reset_model();

    // 16 bit, extreme samples, final byte completes a sample
    put_riff_head();
    put_fmt(16, 16'd1, 16'd1, 32'd48000, 16'd16);
    put_le(ID_DATA, 4);
    put_le(32'd8, 4);
    put_le(32'h8000_7FFF, 4);
    put_le(32'hFFFF_0000, 4);
    ship_file(0);
    // 24 bit, odd fmt with pad, endless data chunk cut mid-sample
    put_riff_head();
    put_fmt(17, 16'd1, 16'd1, 32'hFFFF_FFFF, 16'd24);
    put_le(ID_DATA, 4);
    put_le(32'hFFFF_FFFF, 4);
    put_le(32'h7F_FFFF, 3);
    put_le(32'h80_0000, 3);
    put_le(32'hFF_FFFF, 3);
    put_le(32'h00_0001, 3);
    put_random(1);
    ship_file(0);
    // broken RIFF tag, broken WAVE tag, files too short for a header
    put_le(ID_RIFF ^ 32'h0100_0000, 4);
    put_random(10);
    ship_file(0);
    put_le(ID_RIFF, 4);
    put_random(4);
    put_le(ID_WAVE ^ 32'h0000_0001, 4);
    put_fmt(16, 16'd1, 16'd1, 32'd8000, 16'd16);
    put_filler(ID_DATA, 4);
    ship_file(0);
    put_le(ID_RIFF, 4);
    put_random(3);
    ship_file(0);
    put_random(1);
    ship_file(0);
    // header only, ending on the last WAVE byte
    put_riff_head();
    ship_file(0);
    // data before any fmt
    put_riff_head();
    put_filler(ID_DATA, 4);
    ship_file(0);
    // each format rejection
    put_wav(16, 16'd3, 16'd1, 32'd44100, 16'd16, 4);
    ship_file(0);
    put_wav(16, 16'd1, 16'd2, 32'd44100, 16'd16, 4);
    ship_file(0);
    put_wav(16, 16'd1, 16'd1, 32'd44100, 16'd8, 4);
    ship_file(0);
    put_wav(16, 16'd1, 16'd1, 32'd44100, 16'd32, 4);
    ship_file(0);
    // short fmt: rate half read, bit depth reads as zero
    put_wav(6, 16'd1, 16'd1, 32'h0001_AC44, 16'd16, 4);
    ship_file(0);
    // empty fmt chunk leaves the format tag at zero
    put_wav(0, 16'd1, 16'd1, 32'd8000, 16'd16, 4);
    ship_file(0);
    // extensible fmt size, exact 24 bit data
    put_wav(18, 16'd1, 16'd1, 32'd192000, 16'd24, 6);
    ship_file(0);
    // second fmt overrides the first, odd and empty chunks skipped,
    // partial sample at data end, trailing chunk ignored
    put_riff_head();
    put_fmt(16, 16'd3, 16'd2, 32'd8000, 16'd8);
    put_filler(ID_LIST, 5);
    put_filler($urandom, 0);
    put_fmt(16, 16'd1, 16'd1, 32'd22050, 16'd16);
    put_filler(ID_DATA, 5);
    put_filler(ID_LIST, 3);
    ship_file(0);
    // empty data chunk then trailing bytes
    put_wav(16, 16'd1, 16'd1, 32'd96000, 16'd24, 0);
    put_filler(ID_LIST, 4);
    ship_file(0);
    // file ends on a pad byte
    put_riff_head();
    put_filler(ID_LIST, 3);
    ship_file(0);
    // huge skipped chunk cut short
    put_riff_head();
    put_le(ID_LIST, 4);
    put_le(32'hFFFF_FFF0, 4);
    put_random(6);
    ship_file(0);
    // file ends inside a chunk header
    put_riff_head();
    put_le(ID_DATA, 4);
    put_le(32'd2, 2);
    ship_file(0);

    directed_bytes = pending_bytes.size();
    while (pending_bytes.size() < directed_bytes + RANDOM_BYTES) build_random_file();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || byte_chan.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d files in %0d bytes, %0d samples checked, %0d mismatches",
             files_built, bytes_accepted, samples_checked, mismatches);
    $display("status results ok %0d, header %0d, missing %0d, not pcm %0d, not mono %0d, bits %0d",
             status_seen[ST_OK], status_seen[ST_HEADER], status_seen[ST_MISSING],
             status_seen[ST_NOT_PCM], status_seen[ST_NOT_MONO], status_seen[ST_BITS]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> wav_pcm_stream_parser.f
+incdir+hdl
hdl/wps_pkg.sv
hdl/wps_stream_if.sv
hdl/wps_parser.sv
hdl/wps_out_queue.sv
hdl/wav_pcm_stream_parser.sv
hdl/wps_checker.sv
tb/wav_pcm_stream_parser_test.sv
